/* rtl/core/csfc_pkg.sv */
// Shared types, constants and arithmetic helpers of the cartesian/spherical
// frame converter. Depends on nothing; imported by all modules but the checker.
`default_nettype none

package csfc_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int VW            = 60;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_AW       = 2;

    localparam logic [31:0] GAIN_INV  = 32'h9B74EDA8;
    localparam logic [31:0] ANG_PI    = 32'h80000000;
    localparam logic [31:0] POLAR_MAX = 32'h7FFFFFFF;

    localparam logic [1:0] REQ_C2S   = 2'd0;
    localparam logic [1:0] REQ_S2C   = 2'd1;
    localparam logic [1:0] REQ_FRAME = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [30:0] OBL_COS_RST = 31'd985138864;
    localparam logic [30:0] OBL_SIN_RST = 31'd427109969;

    typedef struct packed {
        logic [1:0]         req;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic               fe;
        logic               xy_zero;
        logic               all_zero;
        logic               frame_pass;
    } t_item;

    typedef struct packed {
        logic [30:0] obl_cos;
        logic [30:0] obl_sin;
    } t_cfg;

    typedef struct packed {
        logic [1:0]            req;
        logic signed [31:0]    a;
        logic signed [31:0]    b;
        logic signed [31:0]    c;
        logic                  fe;
        logic                  xy_zero;
        logic                  all_zero;
        logic                  frame_pass;
        logic                  vec;
        logic                  flip;
        logic signed [VW-1:0]  x;
        logic signed [VW-1:0]  y;
        logic [31:0]           z;
        logic [31:0]           phi;
        logic signed [31:0]    ct;
        logic signed [31:0]    st;
        logic signed [31:0]    cp;
        logic signed [31:0]    sp;
        logic [63:0]           gh;
        logic [63:0]           gl;
        logic signed [63:0]    p0;
        logic signed [63:0]    p1;
        logic signed [63:0]    p2;
        logic signed [63:0]    p3;
        logic signed [33:0]    rs;
        logic [31:0]           oa;
        logic [31:0]           ob;
        logic [31:0]           oc;
        logic                  sat;
    } t_stage;

    function automatic logic [31:0] atan_at(input int k);
        case (k)
            0:  return 32'h20000000;
            1:  return 32'h12E4051E;
            2:  return 32'h09FB385B;
            3:  return 32'h051111D4;
            4:  return 32'h028B0D43;
            5:  return 32'h0145D7E1;
            6:  return 32'h00A2F61E;
            7:  return 32'h00517C55;
            8:  return 32'h0028BE53;
            9:  return 32'h00145F2F;
            10: return 32'h000A2F98;
            11: return 32'h000517CC;
            12: return 32'h00028BE6;
            13: return 32'h000145F3;
            14: return 32'h0000A2FA;
            15: return 32'h0000517D;
            16: return 32'h000028BE;
            17: return 32'h0000145F;
            18: return 32'h00000A30;
            19: return 32'h00000518;
            20: return 32'h0000028C;
            21: return 32'h00000146;
            22: return 32'h000000A3;
            23: return 32'h00000051;
            24: return 32'h00000029;
            25: return 32'h00000014;
            26: return 32'h0000000A;
            27: return 32'h00000005;
            28: return 32'h00000003;
            29: return 32'h00000001;
            30: return 32'h00000001;
            default: return 32'h00000000;
        endcase
    endfunction

    // one micro-rotation; vectoring drives y to zero, rotation drives z to zero
    function automatic t_stage cordic_step(input t_stage s, input int k);
        t_stage               r;
        logic                 dir;
        logic signed [VW-1:0] dx;
        logic signed [VW-1:0] dy;
        r   = s;
        dir = s.vec ? ~s.y[VW-1] : s.z[31];
        dx  = $signed(s.y) >>> k;
        dy  = $signed(s.x) >>> k;
        if (dir) begin
            r.x = s.x + dx;
            r.y = s.y - dy;
            r.z = s.z + atan_at(k);
        end else begin
            r.x = s.x - dx;
            r.y = s.y + dy;
            r.z = s.z - atan_at(k);
        end
        return r;
    endfunction

    function automatic t_stage vec_init(input t_stage s, input logic signed [VW-1:0] xi,
                                        input logic signed [VW-1:0] yi);
        t_stage r;
        r      = s;
        r.vec  = 1'b1;
        r.flip = 1'b0;
        if (xi[VW-1]) begin
            r.x = -xi;
            r.y = -yi;
            r.z = ANG_PI;
        end else begin
            r.x = xi;
            r.y = yi;
            r.z = 32'd0;
        end
        return r;
    endfunction

    function automatic t_stage rot_init(input t_stage s, input logic [31:0] ang);
        t_stage r;
        logic   fold;
        r      = s;
        fold   = ($signed(ang) > 32'sh40000000) || ($signed(ang) < -32'sh40000000);
        r.vec  = 1'b0;
        r.flip = fold;
        r.x    = $signed({{(VW-40){1'b0}}, GAIN_INV, 8'd0});
        r.y    = '0;
        r.z    = fold ? (ang ^ ANG_PI) : ang;
        return r;
    endfunction

    function automatic logic [31:0] round10(input logic signed [VW-1:0] v, input logic flip);
        logic signed [VW-1:0] t;
        t = v + $signed(VW'(512));
        t = t >>> 10;
        if (flip) begin
            t = -t;
        end
        return t[31:0];
    endfunction

    function automatic logic signed [69:0] round30(input logic signed [69:0] v);
        logic signed [69:0] t;
        t = v + 70'sd536870912;
        return t >>> 30;
    endfunction

    // {clipped, value}
    function automatic logic [32:0] sat32(input logic signed [69:0] v);
        if (v > 70'sd2147483647) begin
            return {1'b1, 32'h7FFFFFFF};
        end
        if (v < -70'sd2147483648) begin
            return {1'b1, 32'h80000000};
        end
        return {1'b0, v[31:0]};
    endfunction

    // gain removal: hi * G + round(lo * G / 2^32)
    function automatic logic [60:0] mag_fin(input logic [63:0] gh, input logic [63:0] gl);
        logic [64:0] t;
        t = {1'b0, gl} + 65'h0_8000_0000;
        return gh[60:0] + {28'd0, t[64:32]};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/csfc_front.sv */
// Front end: configuration registers on the APB port, input item accept and
// classification. Depends on csfc_pkg.
`default_nettype none

module csfc_front import csfc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // in_a, in_b, in_c
    input  wire logic [3:0]  s_axis_tuser,  // req_type[1:0], from_equatorial, to_equatorial
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_ready,
    output logic             o_valid,
    output t_item            o_item,
    output t_cfg             o_cfg
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    t_cfg  r_cfg;
    logic  w_acc;

    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? {1'b0, r_cfg.obl_sin} : {1'b0, r_cfg.obl_cos};
    assign s_axis_tready = !r_valid || i_ready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;
    assign o_valid       = r_valid;
    assign o_item        = r_item;
    assign o_cfg         = r_cfg;

    always_comb begin
        n_item.req        = s_axis_tuser[1:0];
        n_item.a          = s_axis_tdata[31:0];
        n_item.b          = s_axis_tdata[63:32];
        n_item.c          = s_axis_tdata[95:64];
        n_item.fe         = s_axis_tuser[2];
        n_item.xy_zero    = (s_axis_tdata[63:0] == 64'd0);
        n_item.all_zero   = (s_axis_tdata == 96'd0);
        n_item.frame_pass = (s_axis_tuser[2] == s_axis_tuser[3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid       <= 1'b0;
            r_cfg.obl_cos <= OBL_COS_RST;
            r_cfg.obl_sin <= OBL_SIN_RST;
        end else begin
            if (w_acc) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
            if (psel && penable && pwrite) begin
                if (paddr[2]) begin
                    r_cfg.obl_sin <= pwdata[30:0];
                end else begin
                    r_cfg.obl_cos <= pwdata[30:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_item <= n_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csfc_fifo.sv */
// Short item queue between the front end and the arithmetic pipeline.
// Depends on csfc_pkg.
`default_nettype none

module csfc_fifo import csfc_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  t_item     i_item,
    output logic      o_ready,
    output logic      o_valid,
    output t_item     o_item,
    input  wire logic i_pop
);

    t_item              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_cnt;
    logic               w_push;
    logic               w_pop;

    assign o_ready = (r_cnt != (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/csfc_back.sv */
// Back end: two unrolled CORDIC chains, gain removal, products, rounding,
// clipping and the output register. Depends on csfc_pkg.
`default_nettype none

module csfc_back import csfc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    input  t_item            i_item,
    output logic             o_pop,
    input  t_cfg             i_cfg,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // out_a, out_b, out_c
    output logic [0:0]       m_axis_tuser   // saturated
);

    localparam int N = CORDIC_STAGES;

    logic             w_en;
    logic [N:0]       r_va;
    logic [N:0]       r_vb;
    logic             r_vh1;
    logic             r_vh2;
    logic             r_vh3;
    logic             r_vo;
    t_stage           r_pa [0:N];
    t_stage           r_pb [0:N];
    t_stage           r_g1;
    t_stage           r_h1;
    t_stage           r_h2;
    t_stage           r_h3;
    t_stage           n_a0;
    t_stage           n_g1;
    t_stage           n_b0;
    t_stage           n_h1;
    t_stage           n_h2;
    t_stage           n_h3;
    logic             r_vg1;
    logic [95:0]      r_odata;
    logic             r_osat;

    assign w_en          = !r_vo || m_axis_tready;
    assign o_pop         = w_en && i_valid;
    assign m_axis_tvalid = r_vo;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_osat;

    always_comb begin
        n_a0            = '0;
        n_a0.req        = i_item.req;
        n_a0.a          = i_item.a;
        n_a0.b          = i_item.b;
        n_a0.c          = i_item.c;
        n_a0.fe         = i_item.fe;
        n_a0.xy_zero    = i_item.xy_zero;
        n_a0.all_zero   = i_item.all_zero;
        n_a0.frame_pass = i_item.frame_pass;
        if (i_item.req == REQ_C2S) begin
            n_a0 = vec_init(n_a0, $signed({{(VW-56){i_item.a[31]}}, i_item.a, 24'd0}),
                            $signed({{(VW-56){i_item.b[31]}}, i_item.b, 24'd0}));
        end else begin
            n_a0 = rot_init(n_a0, i_item.b);
        end
    end

    always_comb begin
        logic [VW-1:0] xv;
        logic [27:0]   hi;
        n_g1 = r_pa[N];
        xv   = r_pa[N].x[VW-1] ? '0 : r_pa[N].x;
        hi   = xv[VW-1:32];
        if (r_pa[N].req == REQ_C2S) begin
            n_g1.gh  = hi * GAIN_INV;
            n_g1.gl  = xv[31:0] * GAIN_INV;
            n_g1.phi = r_pa[N].z;
        end else begin
            n_g1.ct = round10(r_pa[N].x, r_pa[N].flip);
            n_g1.st = round10(r_pa[N].y, r_pa[N].flip);
        end
    end

    always_comb begin
        logic [60:0] rxy;
        rxy  = mag_fin(r_g1.gh, r_g1.gl);
        n_b0 = r_g1;
        if (r_g1.req == REQ_C2S) begin
            n_b0 = vec_init(r_g1, $signed({{(VW-56){r_g1.c[31]}}, r_g1.c, 24'd0}),
                            $signed(rxy[VW-1:0]));
        end else begin
            n_b0 = rot_init(r_g1, r_g1.c);
        end
    end

    always_comb begin
        logic [VW-1:0]      xv;
        logic [27:0]        hi;
        logic signed [31:0] co;
        logic signed [31:0] si;
        n_h1 = r_pb[N];
        xv   = r_pb[N].x[VW-1] ? '0 : r_pb[N].x;
        hi   = xv[VW-1:32];
        co   = $signed({1'b0, i_cfg.obl_cos});
        si   = $signed({1'b0, i_cfg.obl_sin});
        case (r_pb[N].req)
            REQ_C2S: begin
                n_h1.gh = hi * GAIN_INV;
                n_h1.gl = xv[31:0] * GAIN_INV;
            end
            REQ_S2C: begin
                n_h1.cp = round10(r_pb[N].x, r_pb[N].flip);
                n_h1.sp = round10(r_pb[N].y, r_pb[N].flip);
            end
            REQ_FRAME: begin
                n_h1.p0 = $signed(r_pb[N].b) * co;
                n_h1.p1 = $signed(r_pb[N].c) * si;
                n_h1.p2 = $signed(r_pb[N].c) * co;
                n_h1.p3 = $signed(r_pb[N].b) * si;
            end
            default: begin
                n_h1.gh = '0;
            end
        endcase
    end

    always_comb begin
        logic [60:0]        r;
        logic [61:0]        rt;
        logic [32:0]        cab;
        logic [37:0]        rad;
        logic signed [63:0] m1;
        logic signed [63:0] m2;
        logic signed [69:0] ny;
        logic signed [69:0] nz;
        logic signed [69:0] t1;
        logic [32:0]        s1;
        logic [32:0]        s2;
        n_h2 = r_h1;
        r    = mag_fin(r_h1.gh, r_h1.gl);
        rt   = {1'b0, r} + 62'd8388608;
        cab  = r_h1.c[31] ? (33'd0 - {r_h1.c[31], r_h1.c}) : {1'b0, r_h1.c};
        rad  = r_h1.xy_zero ? {5'd0, cab} : rt[61:24];
        m1   = $signed(r_h1.a) * $signed(r_h1.st);
        m2   = $signed(r_h1.a) * $signed(r_h1.ct);
        ny   = r_h1.fe ? (70'(r_h1.p0) + 70'(r_h1.p1)) : (70'(r_h1.p0) - 70'(r_h1.p1));
        nz   = r_h1.fe ? (70'(r_h1.p2) - 70'(r_h1.p3)) : (70'(r_h1.p3) + 70'(r_h1.p2));
        t1   = round30(70'(m1));
        s1   = '0;
        s2   = '0;
        case (r_h1.req)
            REQ_C2S: begin
                n_h2.sat = (rad > 38'd2147483647);
                n_h2.oa  = n_h2.sat ? POLAR_MAX : rad[31:0];
                if (r_h1.xy_zero) begin
                    n_h2.ob = ($signed(r_h1.c) > 0) ? 32'd0 : POLAR_MAX;
                    n_h2.oc = 32'd0;
                end else begin
                    n_h2.ob = r_h1.z[31] ? (r_h1.z[30] ? 32'd0 : POLAR_MAX) : r_h1.z;
                    n_h2.oc = r_h1.phi;
                end
                if (r_h1.all_zero) begin
                    n_h2.oa  = '0;
                    n_h2.ob  = '0;
                    n_h2.oc  = '0;
                    n_h2.sat = 1'b0;
                end
            end
            REQ_S2C: begin
                s1       = sat32(round30(70'(m2)));
                n_h2.rs  = t1[33:0];
                n_h2.oc  = s1[31:0];
                n_h2.sat = s1[32];
                n_h2.oa  = '0;
                n_h2.ob  = '0;
            end
            REQ_FRAME: begin
                n_h2.oa = r_h1.a;
                if (r_h1.frame_pass) begin
                    n_h2.ob  = r_h1.b;
                    n_h2.oc  = r_h1.c;
                    n_h2.sat = 1'b0;
                end else begin
                    s1       = sat32(round30(ny));
                    s2       = sat32(round30(nz));
                    n_h2.ob  = s1[31:0];
                    n_h2.oc  = s2[31:0];
                    n_h2.sat = s1[32] | s2[32];
                end
            end
            default: begin
                n_h2.oa  = '0;
                n_h2.ob  = '0;
                n_h2.oc  = '0;
                n_h2.sat = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic signed [65:0] q1;
        logic signed [65:0] q2;
        logic [32:0]        s1;
        logic [32:0]        s2;
        n_h3 = r_h2;
        q1   = $signed(r_h2.rs) * $signed(r_h2.cp);
        q2   = $signed(r_h2.rs) * $signed(r_h2.sp);
        s1   = sat32(round30(70'(q1)));
        s2   = sat32(round30(70'(q2)));
        if (r_h2.req == REQ_S2C) begin
            n_h3.oa  = s1[31:0];
            n_h3.ob  = s2[31:0];
            n_h3.sat = r_h2.sat | s1[32] | s2[32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va  <= '0;
            r_vb  <= '0;
            r_vg1 <= 1'b0;
            r_vh1 <= 1'b0;
            r_vh2 <= 1'b0;
            r_vh3 <= 1'b0;
            r_vo  <= 1'b0;
        end else if (w_en) begin
            r_va  <= {r_va[N-1:0], o_pop};
            r_vg1 <= r_va[N];
            r_vb  <= {r_vb[N-1:0], r_vg1};
            r_vh1 <= r_vb[N];
            r_vh2 <= r_vh1;
            r_vh3 <= r_vh2;
            r_vo  <= r_vh3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pa[0] <= n_a0;
            r_g1    <= n_g1;
            r_pb[0] <= n_b0;
            r_h1    <= n_h1;
            r_h2    <= n_h2;
            r_h3    <= n_h3;
            r_odata <= {r_h3.oc, r_h3.ob, r_h3.oa};
            r_osat  <= r_h3.sat;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pa[k+1] <= cordic_step(r_pa[k], k);
                r_pb[k+1] <= cordic_step(r_pb[k], k);
            end
        end
    end

endmodule

`default_nettype wire

/* rtl/core/cartesian_spherical_frame_converter_top.sv */
// Path to output valid: front-end register, queue, first CORDIC chain, gain
// register, second CORDIC chain, product and rounding registers, output register.
// Throughput: one item per cycle through two unrolled CORDIC chains, while unstalled.
// A four-entry queue decouples input accept from output backpressure.
// Reset: synchronous, active low; clears all valid state and loads the
// default obliquity cosine and sine.
`default_nettype none

module cartesian_spherical_frame_converter_top import csfc_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [95:0] s_axis_tdata,  // in_a, in_b, in_c
    input  wire logic [3:0]  s_axis_tuser,  // req_type[1:0], from_equatorial, to_equatorial
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [95:0]      m_axis_tdata,  // out_a, out_b, out_c
    output logic [0:0]       m_axis_tuser,  // saturated
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_item w_f_item;
    t_item w_q_item;
    t_cfg  w_cfg;
    logic  w_f_valid;
    logic  w_q_ready;
    logic  w_q_valid;
    logic  w_pop;

    csfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .i_ready       (w_q_ready),
        .o_valid       (w_f_valid),
        .o_item        (w_f_item),
        .o_cfg         (w_cfg)
    );

    csfc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_f_valid),
        .i_item  (w_f_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    csfc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_q_valid),
        .i_item        (w_q_item),
        .o_pop         (w_pop),
        .i_cfg         (w_cfg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

/* rtl/core/csfc_checker.sv */
// Port-level checks for the converter top level, attached by bind.
// Depends only on the top level's ports.
`default_nettype none

module csfc_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic [95:0] s_axis_tdata,
    input wire logic [3:0]  s_axis_tuser,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [95:0] m_axis_tdata,
    input wire logic [0:0]  m_axis_tuser,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("output valid right after reset");

    a_sat_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |->
            (m_axis_tdata[31:0] == 32'h7FFFFFFF) || (m_axis_tdata[31:0] == 32'h80000000) ||
            (m_axis_tdata[63:32] == 32'h7FFFFFFF) || (m_axis_tdata[63:32] == 32'h80000000) ||
            (m_axis_tdata[95:64] == 32'h7FFFFFFF) || (m_axis_tdata[95:64] == 32'h80000000))
        else $error("saturated flag without a clipped component");

    a_cfg_readback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(psel && penable && pwrite && pready) &&
            psel && !pwrite && (paddr[2] == $past(paddr[2])) |->
            prdata == {1'b0, $past(pwdata[30:0])})
        else $error("register readback mismatch");

endmodule

bind cartesian_spherical_frame_converter_top csfc_checker u_csfc_checker (.*);

`default_nettype wire
